>>> rtl/sgik_pkg.sv
// ----------------------------------------------------------------------------
// Sine-gait leg kinematics package
// Transaction types, register indexes, fixed-point constants and the CORDIC
// arctangent table shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package sgik_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LINK_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LINK_LENGTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REACH_MINIMUM     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REACH_MAXIMUM     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_MODE      = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_UPPER_LINK = 16'd3840;
	localparam logic [15:0] RST_LOWER_LINK = 16'd5120;
	localparam logic [15:0] RST_REACH_MIN  = 16'd1280;
	localparam logic [15:0] RST_REACH_MAX  = 16'd8960;

	// Width of the shared step counter (divider, square root and CORDIC).
	localparam int CNT_W = 5;

	// Angles are Q2.30 radians.
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [37:0] TWO_PI_Q30  = 38'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	// Degrees to radians, Q38.
	localparam logic signed [33:0] DEG_TO_RAD_Q38 = 34'sd4797524517;

	// One leg update.
	typedef struct packed {
		logic [31:0]        time_stamp;
		logic [1:0]         leg_number;
		logic signed [15:0] stance_height;
		logic signed [15:0] stride_length;
		logic signed [15:0] lift_amplitude;
		logic signed [15:0] press_amplitude;
		logic [15:0]        flight_fraction;
		logic [15:0]        stride_frequency;
		logic [15:0]        phase_offset;
		logic               walk_backward;
		logic signed [15:0] tilt_degrees;
	} cmd_t;

	// One joint result.
	typedef struct packed {
		logic [1:0]         leg_echo;
		logic signed [15:0] hip_angle;
		logic signed [15:0] knee_angle;
		logic signed [15:0] foot_x;
		logic signed [15:0] foot_y;
	} res_t;

	// Arctangent of 2^-i in Q2.30 radians.
	function automatic logic [30:0] atan_q30(input logic [CNT_W-1:0] idx);
		logic [30:0] v;
		case (idx)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043837;
			5'd3:  v = 31'd133525159;
			5'd4:  v = 31'd67021687;
			5'd5:  v = 31'd33543516;
			5'd6:  v = 31'd16775851;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194283;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048576;
			5'd11: v = 31'd524288;
			5'd12: v = 31'd262144;
			5'd13: v = 31'd131072;
			5'd14: v = 31'd65536;
			5'd15: v = 31'd32768;
			5'd16: v = 31'd16384;
			5'd17: v = 31'd8192;
			5'd18: v = 31'd4096;
			5'd19: v = 31'd2048;
			5'd20: v = 31'd1024;
			5'd21: v = 31'd512;
			5'd22: v = 31'd256;
			5'd23: v = 31'd128;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

	// Saturate a wide signed value to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'sd32767;
		end else if (v < -64'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/sgik_chan_if.sv
// ----------------------------------------------------------------------------
// Sine-gait leg kinematics channels
// Valid/ready channels for leg updates and joint results.
// ----------------------------------------------------------------------------
interface sgik_cmd_if;
	logic           valid;
	logic           ready;
	sgik_pkg::cmd_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface sgik_res_if;
	logic           valid;
	logic           ready;
	sgik_pkg::res_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/sine_gait_leg_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// Sine-gait leg inverse kinematics core
// Phase accumulation, half-sine foot trajectory, tilt rotation and two-link
// inverse kinematics, run one step at a time through a shared multiplier,
// a bit-serial divider, a digit-serial square root and one CORDIC unit.
// ----------------------------------------------------------------------------
//  channel    | direction | handshake           | payload
//  -----------+-----------+---------------------+------------------------------
//  leg_cmd    | in        | valid / ready       | cmd_t, one leg update
//  joint_res  | out       | valid / ready       | res_t, joint angles and foot
//  wr_*       | in        | wr_en, no wait      | register index and data
//
//  One update runs through four CORDIC runs of CORDIC_STEPS steps each, two
//  square roots, one or two divisions and the multiplier steps, in the order
//  that the sequencer sets.
//  leg_cmd is ready only while the core is idle; a finished result waits in the
//  output register and the core stalls in its last step until that is free.
//  Reset clears the phase and the previous time stamp and loads the
//  configuration registers with their reset values.
module sine_gait_leg_inverse_kinematics_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [sgik_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sgik_pkg::CFG_DATA_W-1:0]  wr_data,
	sgik_cmd_if.sink                         leg_cmd,
	sgik_res_if.source                       joint_res
);
	import sgik_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_PH_MUL, S_PH_ACC, S_DIV_SET, S_DIV, S_X0_MUL, S_TH_MUL, S_TH,
		S_COR, S_Y0_MUL, S_Y0, S_TILT, S_R1, S_R2, S_R3, S_R4, S_R5,
		S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_LEN, S_N1, S_N2, S_N3, S_N4, S_N5,
		S_COSM, S_SM_MUL, S_SM, S_M_INIT, S_N_INIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {J_ARC, J_TILT, J_M, J_N} job_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [34:0] z;
		logic               flip;
		logic               vec;
		logic               zero;
	} cor_t;

	localparam logic signed [63:0] RND38 = 64'sd137438953472;
	localparam logic signed [37:0] RND18 = 38'sd131072;
	localparam logic [61:0]        ONE_SQ = 62'd1152921504606846976;

	// Rotation-mode start: fold the angle into +/- pi/2.
	function automatic cor_t rot_init(input logic signed [34:0] z);
		cor_t c;
		c.x = GAIN_Q30;
		c.y = '0;
		c.vec = 1'b0;
		c.zero = 1'b0;
		c.flip = 1'b0;
		c.z = z;
		if (z > HALF_PI_Q30) begin
			c.z = z - 35'(PI_Q30);
			c.flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			c.z = z + 35'(PI_Q30);
			c.flip = 1'b1;
		end
		return c;
	endfunction

	// Vectoring-mode start: move the vector into the right half plane.
	function automatic cor_t vec_init(input logic signed [33:0] x, input logic signed [33:0] y);
		cor_t c;
		c.x = x;
		c.y = y;
		c.z = '0;
		c.vec = 1'b1;
		c.flip = 1'b0;
		c.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			c.z = (y >= 0) ? 35'(PI_Q30) : -35'(PI_Q30);
			c.x = -x;
			c.y = -y;
		end
		return c;
	endfunction

	// Configuration and gait state.
	logic [15:0] upper_q, lower_q, rmin_q, rmax_q;
	logic        rev_q;
	logic [31:0] phase_q, prev_time_q;

	// Sequencer and datapath registers.
	state_t              state_q;
	job_t                job_q;
	cmd_t                cmd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [63:0]  mul_q, acc_q;
	logic                flight_q;
	logic [16:0]         w_q;
	logic signed [23:0]  x0_q;
	logic signed [25:0]  y0_q;
	logic signed [15:0]  fx_q, fy_q;
	logic [15:0]         len_q;
	logic signed [31:0]  cosm_q;
	logic signed [34:0]  m_q;
	logic                div_cos_q, div_neg_q, sq_sin_q;
	logic [34:0]         div_r_q;
	logic [33:0]         div_d_q;
	logic [30:0]         div_q_q;
	logic [61:0]         sq_v_q, sq_r_q;
	cor_t                cor_q;
	res_t                res_q;
	logic                res_valid_q;

	// Shared multiplier operands.
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_full;

	logic [31:0]        dt_w;
	logic [15:0]        g_w, f_w;
	logic               flight_w;
	logic [16:0]        dn_n, dn_d;
	logic signed [16:0] stride_s, stride_eff;
	logic signed [17:0] w_s, e_w;
	logic [16:0]        wr_w;
	logic signed [15:0] amp_w;
	logic [34:0]        r2_w;
	logic               ge_w;
	logic [61:0]        sq_bit_w, sq_try_w;
	logic signed [33:0] dx_w, dy_w, nx_w, ny_w;
	logic signed [34:0] nz_w, atan_w;
	logic               sigma_w;
	logic signed [25:0] hs_w, p_w;
	logic signed [63:0] den64_w;
	logic [33:0]        mag_w;
	logic [15:0]        len_w, sroot_w, l1_w;
	logic signed [37:0] hip_w, knee_w, shift_w;

	// Phase and division set-up.
	assign dt_w     = cmd_q.time_stamp - prev_time_q;
	assign g_w      = 16'(phase_q[31:16] + cmd_q.phase_offset);
	assign f_w      = (cmd_q.flight_fraction == '0) ? 16'd1 : cmd_q.flight_fraction;
	assign flight_w = (g_w <= f_w);
	assign dn_n     = flight_w ? {1'b0, g_w} : {1'b0, 16'(g_w - f_w)};
	assign dn_d     = flight_w ? {1'b0, f_w} : 17'(17'h10000 - {1'b0, f_w});

	// Trajectory terms.
	assign stride_s   = {cmd_q.stride_length[15], cmd_q.stride_length};
	assign stride_eff = cmd_q.walk_backward ? -stride_s : stride_s;
	assign w_s        = $signed({1'b0, div_q_q[16:0]});
	assign e_w        = flight_q ? (w_s - 18'sd32768) : (18'sd32768 - w_s);
	assign wr_w       = (w_q > 17'd32768) ? 17'(17'h10000 - w_q) : w_q;
	assign amp_w      = flight_q ? cmd_q.lift_amplitude : cmd_q.press_amplitude;
	assign hs_w       = {{2{cmd_q.stance_height[15]}}, cmd_q.stance_height, 8'b0};
	assign p_w        = 26'(mul_q >>> 22);

	// Divider step: shift one bit, subtract when it fits.
	assign r2_w = {div_r_q[33:0], 1'b0};
	assign ge_w = (r2_w >= {1'b0, div_d_q});

	// Square root step.
	assign sq_bit_w = 62'd1 << {cnt_q, 1'b0};
	assign sq_try_w = sq_r_q + sq_bit_w;

	// CORDIC step, shared by rotation and vectoring.
	assign dx_w    = cor_q.y >>> cnt_q;
	assign dy_w    = cor_q.x >>> cnt_q;
	assign atan_w  = 35'(atan_q30(cnt_q));
	assign sigma_w = cor_q.vec ? !(cor_q.y > 0) : (cor_q.z >= 0);
	assign nx_w    = sigma_w ? (cor_q.x - dx_w) : (cor_q.x + dx_w);
	assign ny_w    = sigma_w ? (cor_q.y + dy_w) : (cor_q.y - dy_w);
	assign nz_w    = sigma_w ? (cor_q.z - atan_w) : (cor_q.z + atan_w);

	// Reach and cosine law terms.
	assign sroot_w = sq_r_q[15:0];
	assign l1_w    = (upper_q == '0) ? 16'd1 : upper_q;
	assign den64_w = {30'b0, mul_q[32:0], 1'b0};
	assign mag_w   = (acc_q < 0) ? 34'(-acc_q) : 34'(acc_q);

	always_comb begin
		if (sroot_w < rmin_q) begin
			len_w = rmin_q;
		end else if (sroot_w > rmax_q) begin
			len_w = rmax_q;
		end else begin
			len_w = sroot_w;
		end
		if (len_w == '0) begin
			len_w = 16'd1;
		end
	end

	// Joint angles from the two arctangents.
	assign shift_w = rev_q ? -TWO_PI_Q30 : 38'sd0;
	assign hip_w   = 38'(PI_Q30) - 38'(m_q) - 38'(cor_q.z) + shift_w;
	assign knee_w  = 38'(PI_Q30) + 38'(cor_q.z) - 38'(m_q) - shift_w;

	// Multiplier operand selection by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PH_MUL: begin
				mul_a = 34'(cmd_q.stride_frequency);
				mul_b = 34'(dt_w);
			end
			S_X0_MUL: begin
				mul_a = 34'(stride_eff);
				mul_b = 34'(e_w);
			end
			S_TH_MUL: begin
				mul_a = PI_Q30;
				mul_b = 34'(wr_w);
			end
			S_Y0_MUL: begin
				mul_a = 34'(amp_w);
				mul_b = cor_q.y;
			end
			S_Y0: begin
				mul_a = 34'(cmd_q.tilt_degrees);
				mul_b = DEG_TO_RAD_Q38;
			end
			S_R1: begin
				mul_a = cor_q.x;
				mul_b = 34'(x0_q);
			end
			S_R2: begin
				mul_a = cor_q.y;
				mul_b = 34'(y0_q);
			end
			S_R3: begin
				mul_a = cor_q.x;
				mul_b = 34'(y0_q);
			end
			S_R4: begin
				mul_a = cor_q.y;
				mul_b = 34'(x0_q);
			end
			S_SQ1: begin
				mul_a = 34'(fx_q);
				mul_b = 34'(fx_q);
			end
			S_SQ2: begin
				mul_a = 34'(fy_q);
				mul_b = 34'(fy_q);
			end
			S_N1: begin
				mul_a = 34'(len_q);
				mul_b = 34'(len_q);
			end
			S_N2: begin
				mul_a = 34'(l1_w);
				mul_b = 34'(l1_w);
			end
			S_N3: begin
				mul_a = 34'(lower_q);
				mul_b = 34'(lower_q);
			end
			S_N4: begin
				mul_a = 34'(l1_w);
				mul_b = 34'(len_q);
			end
			S_SM_MUL: begin
				mul_a = 34'(cosm_q);
				mul_b = 34'(cosm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	assign leg_cmd.ready   = (state_q == S_IDLE);
	assign joint_res.valid = res_valid_q;
	assign joint_res.item  = res_q;

	// Sequencer, datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			upper_q     <= RST_UPPER_LINK;
			lower_q     <= RST_LOWER_LINK;
			rmin_q      <= RST_REACH_MIN;
			rmax_q      <= RST_REACH_MAX;
			rev_q       <= 1'b0;
			phase_q     <= '0;
			prev_time_q <= '0;
		end else begin
			mul_q <= mul_full[63:0];

			if (wr_en) begin
				case (wr_index)
					REG_UPPER_LINK_LENGTH: upper_q <= wr_data;
					REG_LOWER_LINK_LENGTH: lower_q <= wr_data;
					REG_REACH_MINIMUM:     rmin_q  <= wr_data;
					REG_REACH_MAXIMUM:     rmax_q  <= wr_data;
					REG_REVERSE_MODE:      rev_q   <= wr_data[0];
					default: ;
				endcase
			end

			if (joint_res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (leg_cmd.valid) begin
						cmd_q   <= leg_cmd.item;
						state_q <= S_PH_MUL;
					end
				end
				S_PH_MUL: begin
					prev_time_q <= cmd_q.time_stamp;
					state_q     <= S_PH_ACC;
				end
				S_PH_ACC: begin
					phase_q <= phase_q + {mul_q[27:0], 4'b0};
					state_q <= S_DIV_SET;
				end
				// Position within the flight or stance half as a Q16 fraction.
				S_DIV_SET: begin
					flight_q  <= flight_w;
					div_d_q   <= 34'(dn_d);
					div_r_q   <= (dn_n >= dn_d) ? 35'(dn_n - dn_d) : 35'(dn_n);
					div_q_q   <= 31'(dn_n >= dn_d);
					div_cos_q <= 1'b0;
					cnt_q     <= CNT_W'(15);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_r_q <= ge_w ? (r2_w - {1'b0, div_d_q}) : r2_w;
					div_q_q <= {div_q_q[29:0], ge_w};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= div_cos_q ? S_COSM : S_X0_MUL;
					end
				end
				S_X0_MUL: begin
					w_q     <= div_q_q[16:0];
					state_q <= S_TH_MUL;
				end
				S_TH_MUL: begin
					x0_q    <= 24'(mul_q >>> 8);
					state_q <= S_TH;
				end
				S_TH: begin
					cor_q   <= rot_init(35'(mul_q >>> 16));
					job_q   <= J_ARC;
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				// One CORDIC iteration per cycle.
				S_COR: begin
					cor_q.x <= nx_w;
					cor_q.y <= ny_w;
					cor_q.z <= nz_w;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
						if (cor_q.flip) begin
							cor_q.x <= -nx_w;
							cor_q.y <= -ny_w;
						end
						if (cor_q.zero) begin
							cor_q.z <= '0;
						end
						case (job_q)
							J_ARC:   state_q <= S_Y0_MUL;
							J_TILT:  state_q <= S_R1;
							J_M:     state_q <= S_N_INIT;
							J_N:     state_q <= S_OUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_Y0_MUL: begin
					state_q <= S_Y0;
				end
				S_Y0: begin
					y0_q    <= flight_q ? (hs_w - p_w) : (hs_w + p_w);
					state_q <= S_TILT;
				end
				S_TILT: begin
					cor_q   <= rot_init(35'(mul_q >>> 16));
					job_q   <= J_TILT;
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				// Rotation of the foot point by the tilt.
				S_R1: begin
					state_q <= S_R2;
				end
				S_R2: begin
					acc_q   <= mul_q;
					state_q <= S_R3;
				end
				S_R3: begin
					acc_q   <= acc_q + mul_q;
					state_q <= S_R4;
				end
				S_R4: begin
					fx_q    <= sat16((acc_q + RND38) >>> 38);
					acc_q   <= mul_q;
					state_q <= S_R5;
				end
				S_R5: begin
					fy_q    <= sat16((acc_q - mul_q + RND38) >>> 38);
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					acc_q   <= mul_q;
					state_q <= S_SQ3;
				end
				S_SQ3: begin
					sq_v_q   <= 62'(acc_q + mul_q);
					sq_r_q   <= '0;
					sq_sin_q <= 1'b0;
					cnt_q    <= CNT_W'(30);
					state_q  <= S_SQRT;
				end
				// Square root, one result bit per cycle.
				S_SQRT: begin
					if (sq_v_q >= sq_try_w) begin
						sq_v_q <= sq_v_q - sq_try_w;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_w;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= sq_sin_q ? S_M_INIT : S_LEN;
					end
				end
				S_LEN: begin
					len_q   <= len_w;
					state_q <= S_N1;
				end
				// Cosine law numerator and denominator.
				S_N1: begin
					state_q <= S_N2;
				end
				S_N2: begin
					acc_q   <= mul_q;
					state_q <= S_N3;
				end
				S_N3: begin
					acc_q   <= acc_q + mul_q;
					state_q <= S_N4;
				end
				S_N4: begin
					acc_q   <= acc_q - mul_q;
					state_q <= S_N5;
				end
				S_N5: begin
					if (acc_q >= den64_w) begin
						cosm_q  <= ONE_Q30;
						state_q <= S_SM_MUL;
					end else if (acc_q <= -den64_w) begin
						cosm_q  <= -ONE_Q30;
						state_q <= S_SM_MUL;
					end else begin
						div_r_q   <= {1'b0, mag_w};
						div_d_q   <= {mul_q[32:0], 1'b0};
						div_q_q   <= '0;
						div_neg_q <= (acc_q < 0);
						div_cos_q <= 1'b1;
						cnt_q     <= CNT_W'(29);
						state_q   <= S_DIV;
					end
				end
				S_COSM: begin
					cosm_q  <= div_neg_q ? -32'(div_q_q) : 32'(div_q_q);
					state_q <= S_SM_MUL;
				end
				S_SM_MUL: begin
					state_q <= S_SM;
				end
				S_SM: begin
					sq_v_q   <= ONE_SQ - mul_q[61:0];
					sq_r_q   <= '0;
					sq_sin_q <= 1'b1;
					cnt_q    <= CNT_W'(30);
					state_q  <= S_SQRT;
				end
				S_M_INIT: begin
					cor_q   <= vec_init(34'(cosm_q), 34'(sq_r_q[30:0]));
					job_q   <= J_M;
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				S_N_INIT: begin
					m_q     <= cor_q.z;
					cor_q   <= vec_init(34'($signed({fx_q, 14'b0})), 34'($signed({fy_q, 14'b0})));
					job_q   <= J_N;
					cnt_q   <= '0;
					state_q <= S_COR;
				end
				// Hand the result over once the output register is free.
				S_OUT: begin
					if (!res_valid_q || joint_res.ready) begin
						res_q.leg_echo   <= cmd_q.leg_number;
						res_q.hip_angle  <= sat16(64'((hip_w + RND18) >>> 18));
						res_q.knee_angle <= sat16(64'((knee_w + RND18) >>> 18));
						res_q.foot_x     <= fx_q;
						res_q.foot_y     <= fy_q;
						res_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A second update is never taken straight after the first.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(leg_cmd.valid && leg_cmd.ready) |=> !leg_cmd.ready)
		else $error("leg update accepted while busy");

	// The divider remainder always stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_r_q < {1'b0, div_d_q}))
		else $error("divider remainder out of range");

	// The CORDIC step index never passes the configured number of steps.
	a_cor_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COR) |-> (cnt_q < CNT_W'(CORDIC_STEPS)))
		else $error("CORDIC step index out of range");

	// A result only appears after the final step.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(joint_res.valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the final step");

endmodule
